[design/sat_pkg.sv]
// Shared types and constants for the sorted array table.
// No dependencies; every other design file takes names from here.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

   localparam int DEPTH_DEF      = 256;
   localparam int ITEM_WIDTH_DEF = 32;

   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int CNT_W    = 9;
   localparam int STATUS_W = 2;

   localparam int CAP_W      = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAPACITY = 1'b0,
      REG_ORDER    = 1'b1
   } csr_reg_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_ERASE  = 2'd2,
      CMD_IGNORE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_PRIME,
      S_INSERT,
      S_ERASE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic rd_req;
      logic ins_step;
      logic ers_step;
      logic finish;
   } ctl_type;

   typedef struct packed {
      cmd_type op;
      logic    full;
      logic    range_err;
      logic    ers_none;
      logic    ins_last;
      logic    ers_last;
   } sts_type;

endpackage

`default_nettype wire

[design/sat_req_if.sv]
// Request channel interface: valid/ready plus command payload.
// Depends on sat_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sat_req_if;
   logic                           valid;
   logic                           ready;
   logic [sat_pkg::CMD_W-1:0]      command;
   logic [sat_pkg::VALUE_W-1:0]    item_value;
   logic [sat_pkg::POS_W-1:0]      position;

   modport source (output valid, command, item_value, position, input ready);
   modport sink   (input valid, command, item_value, position, output ready);
endinterface

`default_nettype wire

[design/sat_rsp_if.sv]
// Response channel interface: valid/ready plus result payload.
// Depends on sat_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sat_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sat_pkg::VALUE_W-1:0]    read_value;
   logic [sat_pkg::CNT_W-1:0]      entry_count;
   logic [sat_pkg::STATUS_W-1:0]   status;

   modport source (output valid, read_value, entry_count, status, input ready);
   modport sink   (input valid, read_value, entry_count, status, output ready);
endinterface

`default_nettype wire

[design/sat_controller.sv]
// Sequencer for the sorted array table: handshakes and walk control.
// Depends on sat_pkg; drives sat_datapath through ctl_type / sts_type.
`timescale 1ns / 1ps
`default_nettype none

module sat_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sat_pkg::ctl_type      ctl,
   input  wire sat_pkg::sts_type sts
);

   sat_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sat_pkg::S_IDLE: begin
            if (req_valid) state_in = sat_pkg::S_CHECK;
         end
         sat_pkg::S_CHECK: begin
            case (sts.op)
               sat_pkg::CMD_INSERT:
                  state_in = sts.full ? sat_pkg::S_FINISH : sat_pkg::S_PRIME;
               sat_pkg::CMD_LOOKUP:
                  state_in = sts.range_err ? sat_pkg::S_FINISH : sat_pkg::S_PRIME;
               sat_pkg::CMD_ERASE:
                  state_in = (sts.range_err || sts.ers_none) ? sat_pkg::S_FINISH
                                                             : sat_pkg::S_PRIME;
               default: state_in = sat_pkg::S_FINISH;
            endcase
         end
         sat_pkg::S_PRIME: begin
            case (sts.op)
               sat_pkg::CMD_INSERT: state_in = sat_pkg::S_INSERT;
               sat_pkg::CMD_ERASE:  state_in = sat_pkg::S_ERASE;
               default:             state_in = sat_pkg::S_FINISH;
            endcase
         end
         sat_pkg::S_INSERT: begin
            if (sts.ins_last) state_in = sat_pkg::S_FINISH;
         end
         sat_pkg::S_ERASE: begin
            if (sts.ers_last) state_in = sat_pkg::S_FINISH;
         end
         sat_pkg::S_FINISH: begin
            if (slot_free) state_in = sat_pkg::S_IDLE;
         end
         default: state_in = sat_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctl          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         sat_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
         end
         sat_pkg::S_PRIME: begin
            ctl.rd_req = 1'b1;
         end
         sat_pkg::S_INSERT: begin
            ctl.rd_req   = 1'b1;
            ctl.ins_step = 1'b1;
         end
         sat_pkg::S_ERASE: begin
            ctl.rd_req   = 1'b1;
            ctl.ers_step = 1'b1;
         end
         sat_pkg::S_FINISH: begin
            ctl.finish = slot_free;
            if (slot_free) rsp_valid_in = 1'b1;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sat_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[design/sat_datapath.sv]
// Datapath for the sorted array table: entry memory, walk counters,
// configuration registers and result register. Depends on sat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sat_datapath #(
   parameter int DEPTH      = sat_pkg::DEPTH_DEF,
   parameter int ITEM_WIDTH = sat_pkg::ITEM_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sat_pkg::ctl_type                  ctl,
   output sat_pkg::sts_type                       sts,
   input  wire logic [sat_pkg::CMD_W-1:0]         req_command,
   input  wire logic [sat_pkg::VALUE_W-1:0]       req_item_value,
   input  wire logic [sat_pkg::POS_W-1:0]         req_position,
   input  wire logic                              csr_we,
   input  wire logic [sat_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sat_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [sat_pkg::VALUE_W-1:0]            rsp_read_value,
   output logic [sat_pkg::CNT_W-1:0]              rsp_entry_count,
   output logic [sat_pkg::STATUS_W-1:0]           rsp_status
);

   localparam int AW  = $clog2(DEPTH);
   localparam int IXW = (AW > sat_pkg::CNT_W) ? AW : sat_pkg::CNT_W;
   localparam int LW  = IXW + 1;
   localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

   logic [ITEM_WIDTH-1:0] entry_mem [DEPTH];

   sat_pkg::cmd_type              op_ff, op_in;
   logic [ITEM_WIDTH-1:0]         val_ff, val_in;
   logic [sat_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [sat_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [IXW-1:0]                idx_ff, idx_in;
   logic [IXW-1:0]                raddr_ff, raddr_in;
   logic                          placing_ff, placing_in;
   logic [ITEM_WIDTH-1:0]         carry_ff, carry_in;
   logic [ITEM_WIDTH-1:0]         rdata_ff;
   logic [sat_pkg::CAP_W-1:0]     cap_ff, cap_in;
   logic                          desc_ff, desc_in;
   logic [sat_pkg::VALUE_W-1:0]   res_value_ff, res_value_in;
   logic [sat_pkg::CNT_W-1:0]     res_count_ff, res_count_in;
   sat_pkg::status_type           res_status_ff, res_status_in;

   logic [LW-1:0]         count_ext, idx_ext, raddr_ext, pos_ext, lim;
   logic                  full, range_err, ahead;
   logic                  rd_en, we;
   logic [ITEM_WIDTH-1:0] wdata;

   assign count_ext = LW'(count_ff);
   assign idx_ext   = LW'(idx_ff);
   assign raddr_ext = LW'(raddr_ff);
   assign pos_ext   = LW'(pos_ff);
   assign lim       = (LW'(cap_ff) > DEPTH_L) ? DEPTH_L : LW'(cap_ff);
   assign full      = count_ext >= lim;
   assign range_err = pos_ext >= count_ext;
   assign ahead     = desc_ff ? (rdata_ff > val_ff) : (rdata_ff < val_ff);
   assign rd_en     = ctl.rd_req && (raddr_ext < count_ext);

   always_comb begin
      sts.op        = op_ff;
      sts.full      = full;
      sts.range_err = range_err;
      sts.ers_none  = (pos_ext + LW'(1)) == count_ext;
      sts.ins_last  = idx_ext == count_ext;
      sts.ers_last  = (idx_ext + LW'(2)) == count_ext;
   end

   always_comb begin
      op_in         = op_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      raddr_in      = raddr_ff;
      placing_in    = placing_ff;
      carry_in      = carry_ff;
      cap_in        = cap_ff;
      desc_in       = desc_ff;
      res_value_in  = res_value_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      we            = 1'b0;
      wdata         = val_ff;

      if (ctl.capture) begin
         op_in      = sat_pkg::cmd_type'(req_command);
         val_in     = ITEM_WIDTH'(req_item_value);
         pos_in     = req_position;
         placing_in = 1'b0;
         case (sat_pkg::cmd_type'(req_command))
            sat_pkg::CMD_INSERT: begin
               idx_in   = '0;
               raddr_in = '0;
            end
            sat_pkg::CMD_ERASE: begin
               idx_in   = IXW'(req_position);
               raddr_in = IXW'(req_position) + IXW'(1);
            end
            default: begin
               idx_in   = IXW'(req_position);
               raddr_in = IXW'(req_position);
            end
         endcase
      end

      if (rd_en) raddr_in = raddr_ff + IXW'(1);

      // insert walk: pass entries ahead of the value, then ripple a carry upward
      if (ctl.ins_step) begin
         idx_in = idx_ff + IXW'(1);
         if (idx_ext == count_ext) begin
            we    = 1'b1;
            wdata = placing_ff ? carry_ff : val_ff;
         end else if (placing_ff) begin
            we       = 1'b1;
            wdata    = carry_ff;
            carry_in = rdata_ff;
         end else if (!ahead) begin
            we         = 1'b1;
            wdata      = val_ff;
            carry_in   = rdata_ff;
            placing_in = 1'b1;
         end
      end

      if (ctl.ers_step) begin
         idx_in = idx_ff + IXW'(1);
         we     = 1'b1;
         wdata  = rdata_ff;
      end

      if (ctl.finish) begin
         res_value_in  = '0;
         res_status_in = sat_pkg::STATUS_OK;
         case (op_ff)
            sat_pkg::CMD_INSERT: begin
               if (full) res_status_in = sat_pkg::STATUS_FULL;
               else      count_in      = count_ff + sat_pkg::CNT_W'(1);
            end
            sat_pkg::CMD_LOOKUP: begin
               if (range_err) res_status_in = sat_pkg::STATUS_RANGE;
               else           res_value_in  = sat_pkg::VALUE_W'(rdata_ff);
            end
            sat_pkg::CMD_ERASE: begin
               if (range_err) res_status_in = sat_pkg::STATUS_RANGE;
               else           count_in      = count_ff - sat_pkg::CNT_W'(1);
            end
            default: begin
               res_status_in = sat_pkg::STATUS_OK;
            end
         endcase
         res_count_in = count_in;
      end

      if (csr_we) begin
         case (sat_pkg::csr_reg_type'(csr_index))
            sat_pkg::REG_CAPACITY: cap_in  = csr_wdata[sat_pkg::CAP_W-1:0];
            sat_pkg::REG_ORDER:    desc_in = csr_wdata[0];
            default:               cap_in  = cap_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) entry_mem[idx_ff[AW-1:0]] <= wdata;
      if (rd_en) rdata_ff <= entry_mem[raddr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cap_ff     <= sat_pkg::CAP_RESET;
         desc_ff    <= 1'b0;
         op_ff      <= sat_pkg::CMD_IGNORE;
         placing_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         cap_ff     <= cap_in;
         desc_ff    <= desc_in;
         op_ff      <= op_in;
         placing_ff <= placing_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      raddr_ff      <= raddr_in;
      carry_ff      <= carry_in;
      res_value_ff  <= res_value_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
   end

   assign rsp_read_value  = res_value_ff;
   assign rsp_entry_count = res_count_ff;
   assign rsp_status      = res_status_ff;

endmodule

`default_nettype wire

[design/sorted_array_table_top.sv]
// Top level of the sorted array table: controller plus datapath.
// Depends on sat_pkg, sat_req_if, sat_rsp_if, sat_controller, sat_datapath.
//
//   channel  | direction | transfer condition      | contents
//   ---------+-----------+-------------------------+--------------------------------
//   req_bus  | in        | valid && ready          | command, item_value, position
//   rsp_bus  | out       | valid && ready          | read_value, entry_count, status
//   csr_*    | in        | csr_we                  | capacity (0), order_descending (1)
//
// One request at a time. Insert walks every stored entry; erase walks from pos to the end,
// unless it removes the last entry; lookup reads one entry; rejected or ignored commands do not walk.
// The walk moves through the entry memory one entry per cycle (one read, one write).
// Entry memory has no reset and needs no clearing pass; reset clears the count.
// A pending result does not block the next request; completion waits for the
// result register to drain.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_table_top #(
   parameter int DEPTH      = sat_pkg::DEPTH_DEF,
   parameter int ITEM_WIDTH = sat_pkg::ITEM_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   sat_req_if.sink                             req_bus,
   sat_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [sat_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sat_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sat_pkg::ctl_type ctl;
   sat_pkg::sts_type sts;

   sat_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   sat_datapath #(
      .DEPTH      (DEPTH),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_command     (req_bus.command),
      .req_item_value  (req_bus.item_value),
      .req_position    (req_bus.position),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_read_value  (rsp_bus.read_value),
      .rsp_entry_count (rsp_bus.entry_count),
      .rsp_status      (rsp_bus.status)
   );

endmodule

`default_nettype wire

[design/sat_checker.sv]
// Port-level checks for sorted_array_table_top, attached by bind.
// Depends on sat_pkg and the top level's port names.
`timescale 1ns / 1ps
`default_nettype none

module sat_checker #(
   parameter int DEPTH = sat_pkg::DEPTH_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [sat_pkg::VALUE_W-1:0]   rsp_read_value,
   input wire logic [sat_pkg::CNT_W-1:0]     rsp_entry_count,
   input wire logic [sat_pkg::STATUS_W-1:0]  rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_entry_count) && $stable(rsp_status))
      else $error("stalled result changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sat_pkg::STATUS_FULL || rsp_status == sat_pkg::STATUS_RANGE)
         |-> rsp_read_value == '0)
      else $error("rejected command returned data");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_entry_count) <= DEPTH)
      else $error("entry count beyond table depth");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind sorted_array_table_top sat_checker #(.DEPTH(DEPTH)) u_sat_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_read_value  (rsp_bus.read_value),
   .rsp_entry_count (rsp_bus.entry_count),
   .rsp_status      (rsp_bus.status)
);

`default_nettype wire
